FILE: hdl/modexp_pkg.sv
// shared types and constants for the modular exponentiation core
`timescale 1ns / 1ps

package modexp_pkg;

  localparam int BASE_W  = 30;
  localparam int EXP_W   = 31;
  localparam int POWER_W = 30;

  // number of exponent bits scanned from bit 0 upward
  localparam int EXP_BITS = 31;

  localparam logic [EXP_W-1:0] EXP_MASK =
    (EXP_BITS >= EXP_W) ? {EXP_W{1'b1}} : EXP_W'((64'd1 << EXP_BITS) - 64'd1);

  localparam logic [29:0] MODULUS = 30'd1000000009;

  // barrett constant floor(2^60 / modulus)
  localparam logic [63:0] BARRETT_MU_WIDE = (64'd1 << 60) / 64'd1000000009;
  localparam logic [30:0] BARRETT_MU      = BARRETT_MU_WIDE[30:0];

  localparam logic [31:0] MOD_X1 = {2'b00, MODULUS};
  localparam logic [31:0] MOD_X2 = {1'b0, MODULUS, 1'b0};

  typedef enum logic [2:0] {
    MX_IDLE,
    MX_NEXT,
    MX_MUL,
    MX_SQR,
    MX_OUT
  } mx_state_e;

  typedef enum logic [2:0] {
    MM_IDLE,
    MM_MU,
    MM_QM,
    MM_RED,
    MM_DONE
  } mm_state_e;

endpackage

FILE: hdl/modexp_mulmod.sv
// modular multiplier: one shared 31x31 multiplier, stepwise barrett reduction
`timescale 1ns / 1ps

module modexp_mulmod
  import modexp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [29:0]        a_i,
  input  logic [29:0]        b_i,
  output logic               done_o,
  output logic [POWER_W-1:0] result_o
);

  mm_state_e state_q, state_d;

  logic [30:0] mul_a, mul_b;
  logic [61:0] prod_d, prod_q;
  logic [31:0] x_q;
  logic [31:0] rem;
  logic [29:0] result_d, result_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MM_IDLE: if (start_i) state_d = MM_MU;
      MM_MU:   state_d = MM_QM;
      MM_QM:   state_d = MM_RED;
      MM_RED:  state_d = MM_DONE;
      MM_DONE: state_d = MM_IDLE;
      default: state_d = MM_IDLE;
    endcase
  end

  // operand select and outputs
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    done_o = 1'b0;
    unique case (state_q)
      MM_IDLE: begin
        mul_a = {1'b0, a_i};
        mul_b = {1'b0, b_i};
      end
      MM_MU: begin
        mul_a = prod_q[59:29];
        mul_b = BARRETT_MU;
      end
      MM_QM: begin
        mul_a = prod_q[61:31];
        mul_b = {1'b0, MODULUS};
      end
      MM_RED:  ;
      MM_DONE: done_o = 1'b1;
      default: ;
    endcase
  end

  assign prod_d = 62'(mul_a) * 62'(mul_b);

  // remainder is below three times the modulus
  assign rem = x_q - prod_q[31:0];

  always_comb begin
    priority if (rem >= MOD_X2) begin
      result_d = 30'(rem - MOD_X2);
    end else if (rem >= MOD_X1) begin
      result_d = 30'(rem - MOD_X1);
    end else begin
      result_d = rem[29:0];
    end
  end

  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (state_q == MM_MU) begin
      x_q <= prod_q[31:0];
    end
    if (state_q == MM_RED) begin
      result_q <= result_d;
    end
  end

endmodule

FILE: hdl/modular_exponentiation_core.sv
// modular exponentiation core: right-to-left square and multiply modulo 1000000009
// a zero exponent goes straight to output; else one modular multiply is done for
//   each set exponent bit and one square for each bit below the top set bit
// one item at a time, taken only in idle; every modular multiply runs on the
//   single shared multiplier of modexp_mulmod
// reset: asynchronous active low, returns to idle with no result pending
`timescale 1ns / 1ps

module modular_exponentiation_core
  import modexp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // base [29:0], exponent [60:30], zero [63:61]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // power [29:0], zero [31:30]
);

  mx_state_e state_q, state_d;

  logic [BASE_W-1:0]  in_base;
  logic [EXP_W-1:0]   in_exp;
  logic [29:0]        base_red;

  logic [29:0]        acc_q, acc_d;
  logic [29:0]        res_q, res_d;
  logic [EXP_W-1:0]   exp_q, exp_d;
  logic               out_valid_q, out_valid_d;
  logic [POWER_W-1:0] out_data_q, out_data_d;

  logic               mm_start;
  logic [29:0]        mm_a, mm_b;
  logic               mm_done;
  logic [POWER_W-1:0] mm_result;

  logic               in_req;
  logic               out_free;

  assign in_base  = s_axis_tdata[29:0];
  assign in_exp   = s_axis_tdata[60:30];
  assign base_red = (in_base >= MODULUS) ? 30'(in_base - MODULUS) : in_base;

  assign in_req   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  modexp_mulmod u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mm_start),
    .a_i      (mm_a),
    .b_i      (mm_b),
    .done_o   (mm_done),
    .result_o (mm_result)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MX_IDLE: if (in_req) state_d = MX_NEXT;
      MX_NEXT: begin
        priority if (exp_q == '0) begin
          state_d = MX_OUT;
        end else if (exp_q[0]) begin
          state_d = MX_MUL;
        end else begin
          state_d = MX_SQR;
        end
      end
      MX_MUL:  if (mm_done) state_d = MX_NEXT;
      MX_SQR:  if (mm_done) state_d = MX_NEXT;
      MX_OUT:  if (out_free) state_d = MX_IDLE;
      default: state_d = MX_IDLE;
    endcase
  end

  // outputs to the handshake and the multiplier
  always_comb begin
    s_axis_tready = 1'b0;
    mm_start      = 1'b0;
    mm_a          = acc_q;
    mm_b          = acc_q;
    unique case (state_q)
      MX_IDLE: s_axis_tready = 1'b1;
      MX_NEXT: begin
        if (exp_q != '0) begin
          mm_start = 1'b1;
          if (exp_q[0]) begin
            mm_a = res_q;
          end
        end
      end
      MX_MUL:  ;
      MX_SQR:  ;
      MX_OUT:  ;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    acc_d       = acc_q;
    res_d       = res_q;
    exp_d       = exp_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    unique case (state_q)
      MX_IDLE: begin
        if (in_req) begin
          acc_d = base_red;
          res_d = 30'd1;
          exp_d = in_exp & EXP_MASK;
        end
      end
      MX_NEXT: ;
      MX_MUL: begin
        if (mm_done) begin
          res_d    = mm_result;
          exp_d[0] = 1'b0;
        end
      end
      MX_SQR: begin
        if (mm_done) begin
          acc_d = mm_result;
          exp_d = exp_q >> 1;
        end
      end
      MX_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_data_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= MX_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    res_q      <= res_d;
    exp_q      <= exp_d;
    out_data_q <= out_data_d;
  end

endmodule

FILE: test/modexp_checker.sv
// checker for the modular exponentiation core: predicts each power and compares results
`timescale 1ns / 1ps

module modexp_checker
  import modexp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [63:0] req_data_i,   // base [29:0], exponent [60:30], zero [63:61]
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [31:0] res_data_i,   // power [29:0], zero [31:30]
  output int unsigned pending_o,
  output int unsigned errors_o
);

  localparam logic [63:0] PRIME = 64'd1000000009;

  typedef struct packed {
    logic [BASE_W-1:0]  base;
    logic [EXP_W-1:0]   exponent;
    logic [POWER_W-1:0] power;
  } power_entry_t;

  power_entry_t expected_powers[$];

  // right-to-left square and multiply over the scanned exponent bits
  function automatic logic [POWER_W-1:0] power_mod(input logic [BASE_W-1:0] b,
                                                    input logic [EXP_W-1:0] e);
    logic [63:0] sq;
    logic [63:0] acc;
    sq  = 64'(b) % PRIME;
    acc = 64'd1;
    for (int k = 0; k < EXP_BITS && k < 64; k++) begin
      if (k < EXP_W && e[k]) begin
        acc = (acc * sq) % PRIME;
      end
      sq = (sq * sq) % PRIME;
    end
    return POWER_W'(acc);
  endfunction

  task automatic report_mismatch(input string what, input power_entry_t want,
                                 input logic [31:0] got);
    $display("%0t ns mismatch: %s base=%0d exponent=%0d expected=%0d got=%0d",
             $time, what, want.base, want.exponent, want.power, got);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    power_entry_t want;
    if (!rst_ni) begin
      expected_powers.delete();
      errors_o   = 0;
      pending_o <= 0;
    end else begin
      if (req_valid_i && req_ready_i) begin
        want.base     = req_data_i[BASE_W-1:0];
        want.exponent = req_data_i[BASE_W +: EXP_W];
        want.power    = power_mod(want.base, want.exponent);
        expected_powers.push_back(want);
      end
      if (res_valid_i && res_ready_i) begin
        if (expected_powers.size() == 0) begin
          want = '0;
          report_mismatch("result with no request waiting", want, res_data_i);
        end else begin
          want = expected_powers.pop_front();
          if (res_data_i[POWER_W-1:0] !== want.power) begin
            report_mismatch("power", want, res_data_i);
          end
          if (res_data_i[31:POWER_W] !== '0) begin
            report_mismatch("padding bits", want, res_data_i);
          end
        end
      end
      pending_o <= expected_powers.size();
    end
  end

endmodule

FILE: test/testbench.sv
// testbench top for the modular exponentiation core: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import modexp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned ITEM_TARGET  = 500;
  localparam int unsigned HOLD_CYCLES  = 800;
  localparam int unsigned SETTLE_LEN   = 320;
  localparam logic [31:0] PRIME        = 32'd1000000009;
  localparam logic [31:0] BASE_TOP     = 32'h3FFF_FFFF;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // base [29:0], exponent [60:30], zero [63:61]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // power [29:0], zero [31:30]

  int unsigned pending;
  int unsigned errors;
  int unsigned sent = 0;
  int unsigned cycles = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;

  modular_exponentiation_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  modexp_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_i (s_axis_tready),
    .req_data_i  (s_axis_tdata),
    .res_valid_i (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_i  (m_axis_tdata),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [63:0] make_request(input logic [31:0] b, input logic [31:0] e);
    return {3'b000, EXP_W'(e), BASE_W'(b)};
  endfunction

  function automatic logic [63:0] random_request();
    logic [31:0] b;
    logic [31:0] e;
    case ($urandom_range(9))
      0: b = 32'd0;
      1: b = 32'd1;
      2: b = PRIME - 1;
      3: b = $urandom_range(BASE_TOP, PRIME);   // at or above the modulus
      4: b = $urandom_range(1000);
      default: b = $urandom_range(PRIME - 1);
    endcase
    case ($urandom_range(9))
      0: e = 32'd0;
      1: e = $urandom_range(3);
      2: e = 32'h7FFF_FFFF;
      3: e = 32'd1 << $urandom_range(EXP_W - 1);
      4: e = $urandom >> $urandom_range(31);
      default: e = $urandom;
    endcase
    return make_request(b, e);
  endfunction

  task automatic send_request(input logic [63:0] req);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sent++;
  endtask

  task automatic drain_requests();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned k;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        // long hold-off so the core fills up and back-pressures its input
        m_axis_tready <= 1'b0;
        k = 0;
        while (k < HOLD_CYCLES) begin
          @(posedge clk_i);
          k++;
        end
        hold_done = 1'b1;
      end
      mode = $urandom_range(3);
      span = $urandom_range(150, 20);
      for (k = 0; k < span; k++) begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(1));
          2: m_axis_tready <= ($urandom_range(3) == 0);
          default: m_axis_tready <= ((k % 8) < 3);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int unsigned burst;
    int unsigned gap;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner cases
    send_request(make_request(0, 0));
    send_request(make_request(PRIME - 1, 0));
    send_request(make_request(0, 1));
    send_request(make_request(0, 32'h7FFF_FFFF));
    send_request(make_request(1, 32'h7FFF_FFFF));
    send_request(make_request(2, 1));
    send_request(make_request(2, 30));
    send_request(make_request(2, 31));
    send_request(make_request(PRIME - 1, 1));
    send_request(make_request(PRIME - 1, 2));
    send_request(make_request(PRIME - 1, 32'h7FFF_FFFF));
    send_request(make_request(BASE_TOP, 3));
    send_request(make_request(PRIME, 5));
    send_request(make_request(PRIME + 1, 32'h7FFF_FFFF));
    send_request(make_request(3, PRIME - 1));
    send_request(make_request(7, PRIME - 2));
    send_request(make_request(123456789, 32'h4000_0000));
    send_request(make_request(BASE_TOP, 32'h7FFF_FFFF));
    drain_requests();

    while (sent < ITEM_TARGET) begin
      if (sent >= 300 && !hold_req) begin
        hold_req = 1'b1;
      end
      burst = $urandom_range(8, 1);
      for (int k = 0; k < burst; k++) begin
        send_request(random_request());
      end
      // gap-free stretches around the long receiver hold-off and early on
      if ((sent >= 120 && sent < 160) || (sent >= 290 && sent < 340)) begin
        gap = 0;
      end else begin
        gap = $urandom_range(12);
      end
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      if ($urandom_range(40) == 0) begin
        drain_requests();
      end
    end

    drain_requests();
    repeat (SETTLE_LEN) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/modexp_pkg.sv
hdl/modexp_mulmod.sv
hdl/modular_exponentiation_core.sv
test/modexp_checker.sv
test/testbench.sv
